[rtl/smt_pkg.sv]
// Package for the sorted multiset table: field widths, operation and status codes,
// and the command/status structs between controller and datapath.
// No dependencies; used by every other file of the block.
`default_nettype none

package smt_pkg;

    localparam int MODE_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // capture mode and key of the incoming transfer
        logic exec;      // insert now, or load the match mask
        logic step;      // retire one match (shift mask, and cells on delete)
        logic out_load;  // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              mask_any;
        logic              out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/smt_ctrl.sv]
// Controller of the sorted multiset table: sequences accept, execute, match walk
// and result hand-over. Depends on smt_pkg.
`default_nettype none

module smt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire smt_pkg::t_stat i_stat,
    output smt_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FIN
    } t_state;

    t_state r_state;
    logic   fin_go;

    assign fin_go     = (r_state == S_FIN) && i_stat.out_free;
    assign o_s_tready = (r_state == S_IDLE) || fin_go;

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = i_s_tvalid && o_s_tready;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.step     = (r_state == S_WALK) && i_stat.mask_any;
        o_cmd.out_load = fin_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (i_stat.mode == smt_pkg::MODE_COUNT ||
                        i_stat.mode == smt_pkg::MODE_DELETE) begin
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_WALK: begin
                    if (!i_stat.mask_any) r_state <= S_FIN;
                end
                S_FIN: begin
                    // The next transfer may be taken in the same cycle the result leaves.
                    if (i_stat.out_free) r_state <= i_s_tvalid ? S_EXEC : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/smt_dpath.sv]
// Datapath of the sorted multiset table: the row of sorted cells with parallel
// comparators, the match mask, the counters and the output register. Depends on smt_pkg.
`default_nettype none

module smt_dpath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [smt_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [smt_pkg::VALUE_W-1:0]    i_value,
    input  wire logic                           i_m_tready,
    input  wire smt_pkg::t_cmd                  i_cmd,
    output smt_pkg::t_stat                      o_stat,
    output logic                                o_m_tvalid,
    output logic [smt_pkg::STATUS_W-1:0]        o_status,
    output logic [smt_pkg::CNT_W-1:0]           o_match_count,
    output logic [smt_pkg::CNT_W-1:0]           o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [smt_pkg::VALUE_W-1:0] r_cell [CAPACITY];
    logic signed [smt_pkg::VALUE_W-1:0] n_cell [CAPACITY];
    logic signed [smt_pkg::VALUE_W-1:0] r_key;
    logic [smt_pkg::MODE_W-1:0]         r_mode;
    logic [CAPACITY-1:0]                r_mask;
    logic [CAPACITY-1:0]                n_mask;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_hits;
    logic                               r_dropped;
    logic                               r_out_valid;
    logic [smt_pkg::STATUS_W-1:0]       r_status;
    logic [smt_pkg::CNT_W-1:0]          r_match_count;
    logic [smt_pkg::CNT_W-1:0]          r_occupancy;

    logic [CAPACITY-1:0]                lt;
    logic [CAPACITY-1:0]                eq;
    logic                               full;
    logic                               is_walk_mode;
    logic [smt_pkg::STATUS_W-1:0]       fin_status;

    assign full         = (r_count == CW'(CAPACITY));
    assign is_walk_mode = (r_mode == smt_pkg::MODE_COUNT) || (r_mode == smt_pkg::MODE_DELETE);

    // Every cell compares against the key at once; only occupied cells take part.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            lt[i] = (CW'(i) < r_count) && (r_cell[i] < r_key);
            eq[i] = (CW'(i) < r_count) && (r_cell[i] == r_key);
        end
    end

    // Insert opens a gap at the first cell not below the key. A walk step retires
    // the first match: every cell from that point on takes its upper neighbour.
    // Cells below the key are exactly those ahead of the run of matches.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            n_mask[i] = r_mask[i];
        end
        if (i_cmd.exec && r_mode == smt_pkg::MODE_INSERT && !full) begin
            if (!lt[0]) n_cell[0] = r_key;
            for (int i = 1; i < CAPACITY; i++) begin
                if (!lt[i]) n_cell[i] = lt[i-1] ? r_key : r_cell[i-1];
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (!lt[i]) begin
                    n_mask[i] = r_mask[i+1];
                    if (r_mode == smt_pkg::MODE_DELETE) n_cell[i] = r_cell[i+1];
                end
            end
            if (!lt[CAPACITY-1]) n_mask[CAPACITY-1] = 1'b0;
        end
    end

    always_comb begin
        if (r_mode == smt_pkg::MODE_INSERT) begin
            fin_status = r_dropped ? smt_pkg::ST_FULL : smt_pkg::ST_DONE;
        end else if (is_walk_mode && r_hits == '0) begin
            fin_status = smt_pkg::ST_NOTFOUND;
        end else begin
            fin_status = smt_pkg::ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (i_cmd.exec) begin
            r_mask <= eq;
        end else begin
            r_mask <= n_mask;
        end
        if (i_cmd.accept) begin
            r_key  <= i_value;
            r_mode <= i_mode;
        end
        if (i_cmd.out_load) begin
            r_status      <= fin_status;
            r_match_count <= smt_pkg::CNT_W'(r_hits);
            r_occupancy   <= smt_pkg::CNT_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hits      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_hits    <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.exec && r_mode == smt_pkg::MODE_INSERT) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_cmd.step) begin
                r_hits <= r_hits + 1'b1;
                if (r_mode == smt_pkg::MODE_DELETE) r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.mask_any = |r_mask;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid    = r_out_valid;
    assign o_status      = r_status;
    assign o_match_count = r_match_count;
    assign o_occupancy   = r_occupancy;

endmodule

`default_nettype wire

[rtl/sorted_multiset_table_core.sv]
// Top level of the sorted multiset table: stream ports, controller and datapath.
// Depends on smt_pkg, smt_ctrl and smt_dpath.
//
//  channel  | direction | ports              | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s (ops)  | in        | i_s_tvalid/o_s_tready | tdata: mode[1:0], value[33:2]
//  m (res)  | out       | o_m_tvalid/i_m_tready | tdata: status[1:0], match_count[6:2],
//           |           |                    |        occupancy[11:7]
//
// Insert and unused codes skip the match walk; count and delete retire one match per
// cycle in the walk by shifting the match mask, and on delete the cells as well.
// Reset (synchronous, active low) empties the table; cells need no clearing pass.
// A result waits in the output register while the next operation is taken; a new
// result waits in the finish state only while the previous one is still held.
`default_nettype none

module sorted_multiset_table_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [smt_pkg::S_TDATA_W-1:0]   i_s_tdata,  // mode, value, zero pad
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [smt_pkg::M_TDATA_W-1:0]        o_m_tdata   // status, match_count, occupancy, pad
);

    smt_pkg::t_cmd                 cmd;
    smt_pkg::t_stat                stat;
    logic [smt_pkg::STATUS_W-1:0]  status;
    logic [smt_pkg::CNT_W-1:0]     match_count;
    logic [smt_pkg::CNT_W-1:0]     occupancy;

    smt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    smt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_s_tdata[smt_pkg::MODE_W-1:0]),
        .i_value       (i_s_tdata[smt_pkg::MODE_W +: smt_pkg::VALUE_W]),
        .i_m_tready    (i_m_tready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_m_tvalid    (o_m_tvalid),
        .o_status      (status),
        .o_match_count (match_count),
        .o_occupancy   (occupancy)
    );

    assign o_m_tdata = {4'b0000, occupancy, match_count, status};

endmodule

`default_nettype wire

[rtl/smt_checker.sv]
// Port-level checks for the sorted multiset table core, bound to the top level.
// Depends on smt_pkg and sorted_multiset_table_core.
`default_nettype none

module smt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [smt_pkg::M_TDATA_W-1:0] o_m_tdata
);

    logic [smt_pkg::STATUS_W-1:0] status;
    logic [smt_pkg::CNT_W-1:0]    match_count;

    assign status      = o_m_tdata[1:0];
    assign match_count = o_m_tdata[6:2];

    // A held result must not change while the sink stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A dropped insert or a missing key never reports matches.
    a_zero_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (status == smt_pkg::ST_FULL || status == smt_pkg::ST_NOTFOUND)
        |-> match_count == '0)
        else $error("non-zero match count with full or not-found status");

    // Only defined status codes appear, and the padding stays clear.
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> status != 2'd3 && o_m_tdata[15:12] == 4'd0)
        else $error("undefined status code or padding set");

endmodule

bind sorted_multiset_table_core smt_checker u_smt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
